@@ rtl/ialu_pkg.sv @@
`timescale 1ns / 1ps
// ialu_pkg: operation codes and control structs for the integer ALU.
// No dependencies.
package ialu_pkg;
  localparam int unsigned ActW = 5;

  typedef enum logic [ActW-1:0] {
    OP_ADD  = 5'd0,
    OP_AND  = 5'd1,
    OP_OR   = 5'd2,
    OP_XOR  = 5'd3,
    OP_SUB  = 5'd4,
    OP_ANDN = 5'd5,
    OP_ORN  = 5'd6,
    OP_XNOR = 5'd7,
    OP_ADDX = 5'd8,
    OP_UMUL = 5'd9,
    OP_SMUL = 5'd10,
    OP_SUBX = 5'd11,
    OP_UDIV = 5'd12,
    OP_SDIV = 5'd13,
    OP_SLL  = 5'd14,
    OP_SRL  = 5'd15,
    OP_SRA  = 5'd16
  } act_e;

  // Start request to the iterative multiply/divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;
endpackage

@@ rtl/ialu_muldiv.sv @@
`timescale 1ns / 1ps
// ialu_muldiv: shared shift-add multiplier / restoring divider on magnitudes.
// Depends on ialu_pkg.
module ialu_muldiv import ialu_pkg::*; #(
  parameter int unsigned DataWidth = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  md_req_t              req_i,
  input  logic [DataWidth-1:0] op_a_i,
  input  logic [DataWidth-1:0] op_b_i,
  output logic                 done_o,
  output logic [DataWidth-1:0] lo_o,
  output logic [DataWidth-1:0] hi_o
);
  localparam int unsigned CntW = $clog2(DataWidth + 1);

  logic [DataWidth-1:0] acc_q, acc_d, lo_q, lo_d, b_q, b_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d, div_q, div_d;
  logic [DataWidth:0]   sum;
  logic [DataWidth:0]   trial;

  always_comb begin
    acc_d  = acc_q;
    lo_d   = lo_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    div_d  = div_q;
    sum    = {1'b0, acc_q} + (lo_q[0] ? {1'b0, b_q} : '0);
    trial  = {acc_q, lo_q[DataWidth-1]} - {1'b0, b_q};
    if (req_i.start) begin
      acc_d  = '0;
      lo_d   = op_a_i;
      b_d    = op_b_i;
      cnt_d  = CntW'(DataWidth);
      busy_d = 1'b1;
      div_d  = req_i.is_div;
    end else if (busy_q) begin
      if (div_q) begin
        // restoring step: shift in next dividend bit, try subtract
        if (!trial[DataWidth]) begin
          acc_d = trial[DataWidth-1:0];
          lo_d  = {lo_q[DataWidth-2:0], 1'b1};
        end else begin
          acc_d = {acc_q[DataWidth-2:0], lo_q[DataWidth-1]};
          lo_d  = {lo_q[DataWidth-2:0], 1'b0};
        end
      end else begin
        acc_d = sum[DataWidth:1];
        lo_d  = {sum[0], lo_q[DataWidth-1:1]};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      div_q  <= div_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    lo_q  <= lo_d;
    b_q   <= b_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  // mul: lo = low word, hi = high word; div: lo = quotient, hi = remainder
  assign lo_o = lo_d;
  assign hi_o = acc_d;

`ifndef SYNTHESIS
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !done_o) else $error("done without busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("start lost");
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q) else $error("busy after done");
`endif
endmodule

@@ rtl/integer_alu_with_condition_codes_top.sv @@
`timescale 1ns / 1ps
// Integer ALU with N/Z/V/C flags and Y register (SPARC-style op set).
// Add/logic/shift ops and divides by zero go straight to ST_FIX; umul/smul and udiv/sdiv
// by a nonzero divisor first run in the one-bit-per-cycle multiply/divide unit (ST_RUN).
// Throughput: one beat at a time; s_axis_tready low while an item is in work.
// A result waits in an output register until taken.
// Reset (rst_ni low, async): flags and Y clear to zero, no result pending.
module integer_alu_with_condition_codes_top import ialu_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] action, [5] set_flags, [37:6] operand_a, [69:38] operand_b, zero fill
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] result, [63:32] y_value, [67:64] flags_nzvc, [68] divide_by_zero
  output logic [71:0] m_axis_tdata
);
  localparam int unsigned W = DATA_WIDTH;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]   st_q, st_d;
  logic [4:0]   act_q;
  logic         upd_q, sa_q, sb_q;
  logic [W-1:0] a_q, b_q;
  logic [3:0]   fl_q, fl_d;
  logic [W-1:0] y_q, y_d;
  logic [31:0]  res_q, res_d;
  logic         dz_q, dz_d;
  logic [W-1:0] lo_q, hi_q;
  logic         done;
  logic [W-1:0] md_lo, md_hi;
  md_req_t      req;

  logic [4:0]   in_act;
  logic [W-1:0] in_a, in_b, mag_a, mag_b;
  assign in_act = s_axis_tdata[4:0];
  assign in_a   = s_axis_tdata[6 +: W];
  assign in_b   = s_axis_tdata[38 +: W];
  assign mag_a  = (in_act == OP_SMUL || in_act == OP_SDIV) && in_a[W-1] ? -in_a : in_a;
  assign mag_b  = (in_act == OP_SMUL || in_act == OP_SDIV) && in_b[W-1] ? -in_b : in_b;

  logic acc_in, is_md_in;
  assign acc_in   = s_axis_tvalid && s_axis_tready;
  assign is_md_in = (in_act == OP_UMUL || in_act == OP_SMUL ||
                     in_act == OP_UDIV || in_act == OP_SDIV) && (in_b != '0 ||
                     in_act == OP_UMUL || in_act == OP_SMUL);
  assign req.start  = acc_in && is_md_in;
  assign req.is_div = (in_act == OP_UDIV || in_act == OP_SDIV);

  ialu_muldiv #(.DataWidth(W)) u_md (
    .clk_i, .rst_ni, .req_i(req), .op_a_i(mag_a), .op_b_i(mag_b),
    .done_o(done), .lo_o(md_lo), .hi_o(md_hi)
  );

  // combinational datapath on the stored operands
  logic [W:0]   s_add, s_sub, subt;
  logic         cin;
  logic [W-1:0] r1, bb, shl, shr, sgn_lo, sgn_hi;
  logic [4:0]   cnt;
  logic         neg_p;
  logic [2*W-1:0] prod;
  logic [3:0]   nz;
  assign cin   = fl_q[0];
  assign s_add = {1'b0, a_q} + {1'b0, b_q} + {{W{1'b0}}, (act_q == OP_ADDX) & cin};
  assign subt  = {1'b0, b_q} + {{W{1'b0}}, (act_q == OP_SUBX) & cin};
  assign s_sub = {1'b0, a_q} - subt;
  assign bb    = (act_q >= OP_ANDN && act_q <= OP_XNOR) ? ~b_q : b_q;
  assign cnt   = b_q[4:0];
  assign shl   = a_q << cnt;
  assign shr   = W'($signed({act_q == OP_SRA & a_q[W-1], a_q}) >>> cnt);
  assign neg_p = sa_q ^ sb_q;
  assign prod  = neg_p ? -{hi_q, lo_q} : {hi_q, lo_q};
  assign sgn_lo = (act_q == OP_SDIV && neg_p) ? -lo_q : lo_q;
  assign sgn_hi = (act_q == OP_SDIV && sa_q) ? -hi_q : hi_q;

  always_comb begin
    r1 = '0;
    case (act_q[1:0])
      2'd1:    r1 = a_q & bb;
      2'd2:    r1 = a_q | bb;
      default: r1 = a_q ^ bb;
    endcase
  end

  always_comb begin
    st_d  = st_q;
    fl_d  = fl_q;
    y_d   = y_q;
    res_d = res_q;
    dz_d  = dz_q;
    nz    = 4'd0;
    case (st_q)
      ST_IDLE: begin
        if (acc_in) st_d = is_md_in ? ST_RUN : ST_FIX;
      end
      ST_RUN: begin
        if (done) st_d = ST_FIX;
      end
      ST_FIX: begin
        st_d = ST_OUT;
        dz_d = 1'b0;
        case (act_q)
          OP_ADD, OP_ADDX: begin
            res_d = 32'(s_add[W-1:0]);
            if (upd_q) fl_d = {s_add[W-1], s_add[W-1:0] == '0,
                               ~(a_q[W-1] ^ b_q[W-1]) & (a_q[W-1] ^ s_add[W-1]), s_add[W]};
          end
          OP_SUB, OP_SUBX: begin
            res_d = 32'(s_sub[W-1:0]);
            if (upd_q) fl_d = {s_sub[W-1], s_sub[W-1:0] == '0,
                               (a_q[W-1] ^ b_q[W-1]) & (a_q[W-1] ^ s_sub[W-1]), s_sub[W]};
          end
          OP_AND, OP_OR, OP_XOR, OP_ANDN, OP_ORN, OP_XNOR: begin
            res_d = 32'(r1);
            if (upd_q) fl_d = {r1[W-1], r1 == '0, 2'b00};
          end
          OP_UMUL, OP_SMUL: begin
            res_d = 32'(prod[W-1:0]);
            y_d   = prod[2*W-1:W];
            nz    = {act_q == OP_SMUL & prod[W-1], prod == '0,
                     prod[2*W-1:W] != '0, 1'b0};
            if (upd_q) fl_d = nz;
          end
          OP_UDIV, OP_SDIV: begin
            if (b_q == '0) begin
              dz_d  = 1'b1;
              res_d = 32'({W{1'b1}});
              y_d   = a_q;
              nz    = {act_q == OP_SDIV, 3'b000};
            end else begin
              res_d = 32'(sgn_lo);
              y_d   = sgn_hi;
              nz    = {act_q == OP_SDIV & sgn_lo[W-1],
                       sgn_lo == '0 && sgn_hi == '0, 2'b00};
            end
            if (upd_q) fl_d = nz;
          end
          OP_SLL:  res_d = 32'(shl);
          OP_SRL, OP_SRA: res_d = 32'(shr);
          default: res_d = '0;
        endcase
      end
      ST_OUT: begin
        if (m_axis_tready) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      fl_q <= 4'd0;
      y_q  <= '0;
    end else begin
      st_q <= st_d;
      fl_q <= fl_d;
      y_q  <= y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    dz_q  <= dz_d;
    if (acc_in) begin
      act_q <= in_act;
      upd_q <= s_axis_tdata[5];
      a_q   <= in_a;
      b_q   <= in_b;
      sa_q  <= (in_act == OP_SMUL || in_act == OP_SDIV) & in_a[W-1];
      sb_q  <= (in_act == OP_SMUL || in_act == OP_SDIV) & in_b[W-1];
    end
    if (done) begin
      lo_q <= md_lo;
      hi_q <= md_hi;
    end
  end

  assign s_axis_tready = (st_q == ST_IDLE);
  assign m_axis_tvalid = (st_q == ST_OUT);
  assign m_axis_tdata  = {3'b000, dz_q, fl_q, 32'(y_q), res_q};

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("overlap");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("drop");
  a_run_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RUN) && done |=> st_q == ST_FIX) else $error("seq");
`endif
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for integer_alu_with_condition_codes_top.
// Depends on ialu_pkg and the top module; drives random and directed ALU beats.
module tb;
  import ialu_pkg::*;

  localparam int unsigned WatchLimit = 4000;

  // packed to match the result tdata layout, lowest field last
  typedef struct packed {
    logic        dz;
    logic [3:0]  nzvc;
    logic [31:0] yv;
    logic [31:0] res;
  } alu_out_t;

  // Scoreboard: keeps its own flags/Y and a queue of expected outputs.
  class alu_scoreboard;
    logic [3:0]  flags;
    logic [31:0] y;
    alu_out_t    pending[$];
    int          errors;

    function new();
      flags = '0;
      y = '0;
      errors = 0;
    endfunction

    function logic [3:0] nz(logic [31:0] r);
      return {r[31], r == 0, 2'b00};
    endfunction

    function void note_input(logic [4:0] act, logic upd, logic [31:0] a, logic [31:0] b);
      alu_out_t    o;
      logic [32:0] s;
      logic [32:0] sub;
      logic [63:0] p;
      logic [31:0] ma, mb, q, r, bb;
      logic [3:0]  nf;
      logic        cin;
      nf = flags;
      cin = flags[0];
      o = '0;
      case (act)
        OP_ADD, OP_ADDX: begin
          s = {1'b0, a} + {1'b0, b} + ((act == OP_ADDX) ? cin : 1'b0);
          o.res = s[31:0];
          if (upd) nf = nz(o.res) | {2'b0, (~(a ^ b) & (a ^ o.res)) >> 31 != 0, s[32]};
        end
        OP_SUB, OP_SUBX: begin
          sub = {1'b0, b} + ((act == OP_SUBX) ? cin : 1'b0);
          o.res = a - sub[31:0];
          if (upd) nf = nz(o.res) | {2'b0, ((a ^ b) & (a ^ o.res)) >> 31 != 0,
                                     {1'b0, a} < sub};
        end
        OP_AND, OP_OR, OP_XOR, OP_ANDN, OP_ORN, OP_XNOR: begin
          bb = (act >= OP_ANDN) ? ~b : b;
          case (act[1:0])
            2'd1: o.res = a & bb;
            2'd2: o.res = a | bb;
            default: o.res = a ^ bb;
          endcase
          if (upd) nf = nz(o.res);
        end
        OP_UMUL, OP_SMUL: begin
          if (act == OP_SMUL) begin
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            p = {32'b0, ma} * {32'b0, mb};
            if (a[31] ^ b[31]) p = -p;
          end else begin
            p = {32'b0, a} * {32'b0, b};
          end
          o.res = p[31:0];
          y = p[63:32];
          if (upd) nf = {(act == OP_SMUL) && o.res[31], o.res == 0 && y == 0, y != 0, 1'b0};
        end
        OP_UDIV, OP_SDIV: begin
          if (b == 0) begin
            o.dz = 1'b1;
            o.res = '1;
            y = a;
          end else if (act == OP_SDIV) begin
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            r = ma % mb;
            if (a[31] ^ b[31]) q = -q;
            if (a[31]) r = -r;
            o.res = q;
            y = r;
          end else begin
            o.res = a / b;
            y = a % b;
          end
          if (upd) nf = {(act == OP_SDIV) && o.res[31], o.res == 0 && y == 0, 2'b00};
        end
        OP_SLL: o.res = a << b[4:0];
        OP_SRL: o.res = a >> b[4:0];
        OP_SRA: o.res = $signed(a) >>> b[4:0];
        default: o.res = '0;
      endcase
      flags = nf;
      o.yv = y;
      o.nzvc = flags;
      pending.push_back(o);
    endfunction

    function void check_result(alu_out_t got);
      alu_out_t w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      w = pending.pop_front();
      if (got.res !== w.res || got.yv !== w.yv || got.nzvc !== w.nzvc || got.dz !== w.dz) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: res %h/%h y %h/%h nzvc %h/%h dz %b/%b (exp/act)",
                   w.res, got.res, w.yv, got.yv, w.nzvc, got.nzvc, w.dz, got.dz);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  alu_scoreboard sb = new();
  int            idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  integer_alu_with_condition_codes_top i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Send one beat after a random gap; note it in the scoreboard on acceptance.
  // tvalid stays up after acceptance only when the next beat follows at once.
  task automatic send_op(logic [4:0] act, logic upd, logic [31:0] a, logic [31:0] b);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, b, a, upd, act};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(act, upd, a, b);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 40);
      5: return -$urandom_range(1, 40);
      default: return $urandom();
    endcase
  endfunction

  // Receiver: random stall per beat, sometimes none.
  initial begin
    int stall;
    forever begin
      stall = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata[68:0]);
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    logic [4:0] op;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: carries, overflow, div by zero, most-negative / -1, shifts, bad codes.
    send_op(OP_ADD, 1'b1, 32'hFFFF_FFFF, 32'h1);
    send_op(OP_ADDX, 1'b1, 32'hFFFF_FFFF, 32'h0);
    send_op(OP_ADD, 1'b1, 32'h7FFF_FFFF, 32'h1);
    send_op(OP_SUB, 1'b1, 32'h0, 32'h1);
    send_op(OP_SUBX, 1'b1, 32'h0, 32'hFFFF_FFFF);
    send_op(OP_SUB, 1'b1, 32'h8000_0000, 32'h1);
    send_op(OP_AND, 1'b1, 32'hF0F0_F0F0, 32'h0F0F_0F0F);
    send_op(OP_OR, 1'b0, 32'h1234_5678, 32'h8000_0000);
    send_op(OP_XOR, 1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_op(OP_ANDN, 1'b1, 32'hFFFF_FFFF, 32'h0);
    send_op(OP_ORN, 1'b1, 32'h0, 32'hFFFF_FFFF);
    send_op(OP_XNOR, 1'b1, 32'hAAAA_AAAA, 32'h5555_5555);
    send_op(OP_UMUL, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_SMUL, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(OP_SMUL, 1'b1, 32'h0, 32'h8000_0000);
    send_op(OP_UDIV, 1'b1, 32'hFFFF_FFFF, 32'h0);
    send_op(OP_SDIV, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(OP_SDIV, 1'b1, 32'hFFFF_FFF9, 32'h2);
    send_op(OP_UDIV, 1'b1, 32'h0, 32'h7);
    send_op(OP_SLL, 1'b1, 32'hFFFF_FFFF, 32'h1F);
    send_op(OP_SRL, 1'b0, 32'h8000_0000, 32'hFFFF_FFE0);
    send_op(OP_SRA, 1'b1, 32'h8000_0000, 32'h1F);
    send_op(5'd17, 1'b1, 32'h1, 32'h1);
    send_op(5'd31, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Random: mostly valid codes, some undefined ones.
    repeat (1530) begin
      op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31))
                                        : 5'($urandom_range(0, 16));
      send_op(op, 1'($urandom_range(0, 1)), rand_operand(), rand_operand());
    end
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
